// ===== src/bdeq_pkg.sv =====
// Package for the bounded double-ended queue: sizes, opcode and status codes,
// the update struct passed from the pointer unit to the top level.
// No dependencies.
`default_nettype none
package bdeq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 64;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int FCNT_W   = 5;   // width of the element_count field
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Write request and post-operation read addresses for one accepted beat.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr_head;
    logic [ADDR_W-1:0] raddr_tail;
    logic [CNT_W-1:0]  count;
    logic              rev;
    status_t           status;
  } ptr_upd_t;

  // Reduce a sum known to be below 2*CAPACITY to a slot index.
  function automatic logic [ADDR_W-1:0] wrap_pos(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = (v >= SUM_W'(CAPACITY)) ? v - SUM_W'(CAPACITY) : v;
    return r[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/bdeq_if.sv =====
// Channel interfaces of the deque: command beats in, result beats out.
// Depends on bdeq_pkg.
`default_nettype none
interface bdeq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [bdeq_pkg::OP_W-1:0]   opcode;
  logic [bdeq_pkg::DATA_W-1:0] data_value;

  modport source (output valid, output opcode, output data_value, input ready);
  modport sink   (input valid, input opcode, input data_value, output ready);
endinterface

interface bdeq_res_if;
  logic                        valid;
  logic                        ready;
  logic [bdeq_pkg::DATA_W-1:0] front_value;
  logic [bdeq_pkg::DATA_W-1:0] back_value;
  logic [bdeq_pkg::FCNT_W-1:0] element_count;
  logic                        is_empty;
  logic [bdeq_pkg::STAT_W-1:0] status;

  modport source (output valid, output front_value, output back_value,
                  output element_count, output is_empty, output status,
                  input ready);
  modport sink   (input valid, input front_value, input back_value,
                  input element_count, input is_empty, input status,
                  output ready);
endinterface
`default_nettype wire

// ===== src/bdeq_ptr.sv =====
// Pointer unit: head index, count and direction flag of the circular buffer.
// Depends on bdeq_pkg.
`default_nettype none
module bdeq_ptr (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [bdeq_pkg::OP_W-1:0]     opcode,
  output bdeq_pkg::ptr_upd_t                 upd
);

  logic [bdeq_pkg::ADDR_W-1:0] head, head_next;
  logic [bdeq_pkg::CNT_W-1:0]  count, count_next;
  logic                        rev, rev_next;

  logic                        full, empty;
  logic [bdeq_pkg::ADDR_W-1:0] head_dec, head_inc, tail_free;
  logic [bdeq_pkg::SUM_W-1:0]  last_sum;
  bdeq_pkg::op_t               op;
  logic                        push_head, push_tail, take_head, take_tail;

  assign op        = bdeq_pkg::op_t'(opcode);
  assign full      = count >= bdeq_pkg::CNT_W'(bdeq_pkg::CAPACITY);
  assign empty     = count == '0;
  assign head_dec  = (head == '0) ? bdeq_pkg::ADDR_W'(bdeq_pkg::CAPACITY - 1)
                                  : head - 1'b1;
  assign head_inc  = (head == bdeq_pkg::ADDR_W'(bdeq_pkg::CAPACITY - 1)) ? '0
                                  : head + 1'b1;
  assign tail_free = bdeq_pkg::wrap_pos(bdeq_pkg::SUM_W'(head) +
                                        bdeq_pkg::SUM_W'(count));

  always_comb begin
    push_head  = 1'b0;
    push_tail  = 1'b0;
    take_head  = 1'b0;
    take_tail  = 1'b0;
    rev_next   = rev;
    upd.status = bdeq_pkg::STAT_DONE;
    case (op)
      bdeq_pkg::OP_PUSH_BACK: begin
        if (full) upd.status = bdeq_pkg::STAT_FULL;
        else if (rev) push_head = 1'b1;
        else push_tail = 1'b1;
      end
      bdeq_pkg::OP_PUSH_FRONT: begin
        if (full) upd.status = bdeq_pkg::STAT_FULL;
        else if (rev) push_tail = 1'b1;
        else push_head = 1'b1;
      end
      bdeq_pkg::OP_POP_FRONT: begin
        if (empty) upd.status = bdeq_pkg::STAT_EMPTY;
        else if (rev) take_tail = 1'b1;
        else take_head = 1'b1;
      end
      bdeq_pkg::OP_POP_BACK: begin
        if (empty) upd.status = bdeq_pkg::STAT_EMPTY;
        else if (rev) take_head = 1'b1;
        else take_tail = 1'b1;
      end
      bdeq_pkg::OP_REVERSE: begin
        if (empty) upd.status = bdeq_pkg::STAT_EMPTY;
        else rev_next = ~rev;
      end
      bdeq_pkg::OP_CLEAR: begin
        rev_next = 1'b0;
      end
      default: begin
      end
    endcase

    head_next = head;
    count_next = count;
    if (op == bdeq_pkg::OP_CLEAR) begin
      head_next  = '0;
      count_next = '0;
    end else if (push_head) begin
      head_next  = head_dec;
      count_next = count + 1'b1;
    end else if (push_tail) begin
      count_next = count + 1'b1;
    end else if (take_head) begin
      head_next  = head_inc;
      count_next = count - 1'b1;
    end else if (take_tail) begin
      count_next = count - 1'b1;
    end

    upd.we    = push_head | push_tail;
    upd.waddr = push_head ? head_dec : tail_free;
    upd.count = count_next;
    upd.rev   = rev_next;

    // Read addresses follow the state after the operation.
    last_sum = bdeq_pkg::SUM_W'(head_next) + bdeq_pkg::SUM_W'(count_next) - 1'b1;
    upd.raddr_head = head_next;
    upd.raddr_tail = (count_next == '0) ? head_next : bdeq_pkg::wrap_pos(last_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (accept) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= bdeq_pkg::CNT_W'(bdeq_pkg::CAPACITY))
    else $error("count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && op == bdeq_pkg::OP_CLEAR |=> count == '0 && head == '0 && !rev)
    else $error("clear left state behind");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && upd.status == bdeq_pkg::STAT_FULL |=> $stable(count) && $stable(head))
    else $error("rejected push changed state");

  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    accept && upd.we |-> upd.status == bdeq_pkg::STAT_DONE && !full)
    else $error("write on a rejected push");

endmodule
`default_nettype wire

// ===== src/bounded_double_ended_queue.sv =====
// Bounded double-ended queue of 64-bit values in a 16-slot circular buffer.
// One command beat (push back/front, pop front/back, reverse, clear) is taken
// per cycle while the result register is free or being drained; its result
// beat appears in the cycle after acceptance. The slot memory takes the
// write and both front/back reads at the edge the command is accepted and
// registers the read data as the result. Slots hold no reset value; only
// occupied slots are ever shown. Depends on bdeq_pkg, bdeq_if and bdeq_ptr.
`default_nettype none
module bounded_double_ended_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  bdeq_cmd_if.sink   cmd,
  bdeq_res_if.source res
);

  logic                        accept;
  bdeq_pkg::ptr_upd_t          upd;

  logic [bdeq_pkg::DATA_W-1:0] slot_mem [bdeq_pkg::CAPACITY];
  logic [bdeq_pkg::DATA_W-1:0] head_val, tail_val;
  logic [bdeq_pkg::CNT_W-1:0]  count_q;
  logic                        rev_q;
  bdeq_pkg::status_t           status_q;
  logic                        valid_q;
  logic                        empty_q;

  assign cmd.ready = ~valid_q | res.ready;
  assign accept    = cmd.valid & cmd.ready;

  bdeq_ptr u_ptr (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (cmd.opcode),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (accept && upd.we) begin
      slot_mem[upd.waddr] <= cmd.data_value;
    end
  end

  // Read both ends; a slot written by this beat is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_val <= (upd.we && upd.waddr == upd.raddr_head) ? cmd.data_value
                                                          : slot_mem[upd.raddr_head];
      tail_val <= (upd.we && upd.waddr == upd.raddr_tail) ? cmd.data_value
                                                          : slot_mem[upd.raddr_tail];
      count_q  <= upd.count;
      rev_q    <= upd.rev;
      status_q <= upd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (res.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign empty_q           = count_q == '0;
  assign res.valid         = valid_q;
  assign res.front_value   = empty_q ? '0 : (rev_q ? tail_val : head_val);
  assign res.back_value    = empty_q ? '0 : (rev_q ? head_val : tail_val);
  assign res.element_count = bdeq_pkg::FCNT_W'(count_q);
  assign res.is_empty      = empty_q;
  assign res.status        = status_q;

  a_ready: assert property (@(posedge clk) disable iff (rst)
    valid_q && !res.ready |-> !cmd.ready)
    else $error("accepted while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> valid_q)
    else $error("accepted beat produced no result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    valid_q && empty_q |-> res.front_value == '0 && res.back_value == '0)
    else $error("empty deque shows data");

endmodule
`default_nettype wire
